>>> rtl/quoted_token_splitter_core_defines.svh
// Assertion macros shared by the quoted token splitter RTL.
// Depends on nothing; included by the top level only.
`ifndef QUOTED_TOKEN_SPLITTER_CORE_DEFINES_SVH
`define QUOTED_TOKEN_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qts same-cycle check failed");

// Next-cycle implication, disabled during reset
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qts next-cycle check failed");

`endif

>>> rtl/qts_pkg.sv
// Shared types and constants for the quoted token splitter.
// No dependencies; imported by every module of the block.
package qts_pkg;

   localparam logic [7:0] QUOTE_SINGLE = 8'h27;
   localparam logic [7:0] QUOTE_DOUBLE = 8'h22;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_MAP_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_MAP_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_MAP_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_MAP_3 = 2'd3;
   localparam int unsigned SEP_WORDS = 4;
   localparam int unsigned CSR_DATA_W = 64;

   // Reset bitmap: tab and space
   localparam logic [CSR_DATA_W-1:0] SEP_MAP_0_RESET = 64'h0000_0001_0000_0200;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TOKEN = 2'd1,
      MODE_QUOTE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SKIP  = 2'd0,
      KIND_FIRST = 2'd1,
      KIND_MORE  = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [1:0] byte_kind;
      logic       token_closed;
      logic       last_out;
   } rsp_type;

   // Classified item, front to back
   typedef struct packed {
      logic [7:0] char_val;
      logic       last;
      logic       sep;
      logic       is_single;
      logic       is_double;
   } class_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/qts_front.sv
// Front end: separator bitmap registers and byte classification.
// Depends on qts_pkg.
module qts_front import qts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   output class_type             cls
);

   logic [CSR_DATA_W-1:0] sep_map_ff [SEP_WORDS];
   logic [CSR_DATA_W-1:0] sep_word;

   // Bitmap registers, written by index
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_map_ff[CSR_SEP_MAP_0] <= SEP_MAP_0_RESET;
         sep_map_ff[CSR_SEP_MAP_1] <= '0;
         sep_map_ff[CSR_SEP_MAP_2] <= '0;
         sep_map_ff[CSR_SEP_MAP_3] <= '0;
      end else if (csr_we) begin
         sep_map_ff[csr_index] <= csr_wdata;
      end
   end

   // Bitmap lookup and quote detection
   always_comb begin
      sep_word      = sep_map_ff[req_data.char_in[7:6]];
      cls.char_val  = req_data.char_in;
      cls.last      = req_data.string_end;
      cls.sep       = sep_word[req_data.char_in[5:0]];
      cls.is_single = (req_data.char_in == QUOTE_SINGLE);
      cls.is_double = (req_data.char_in == QUOTE_DOUBLE);
   end

endmodule

>>> rtl/qts_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on qts_pkg.
module qts_queue import qts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  class_type    push_data,
   input  logic         pop,
   output class_type    head,
   output logic         head_valid,
   output q_status_type status
);

   class_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

>>> rtl/qts_back.sv
// Back end: token state machine and registered result stage.
// Depends on qts_pkg.
module qts_back import qts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  class_type head,
   input  logic      head_valid,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   mode_type mode_ff, mode_in;
   logic     quote_kind_ff, quote_kind_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;
   kind_type kind;
   logic     closed;
   logic     quote_match;

   // Take the head item whenever the result stage is free or draining
   assign pop          = head_valid && (!rsp_valid_ff || rsp_ready);
   assign quote_match  = quote_kind_ff ? head.is_double : head.is_single;
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   // Next state
   always_comb begin
      case (mode_ff)
         MODE_QUOTE: mode_in = quote_match ? MODE_TOKEN : MODE_QUOTE;
         MODE_TOKEN: mode_in = head.sep ? MODE_IDLE : MODE_TOKEN;
         default: begin
            if (head.sep) begin
               mode_in = MODE_IDLE;
            end else if (head.is_single || head.is_double) begin
               mode_in = MODE_QUOTE;
            end else begin
               mode_in = MODE_TOKEN;
            end
         end
      endcase
      // end of string returns to between tokens
      if (head.last) begin
         mode_in = MODE_IDLE;
      end
   end

   // Outputs: byte kind, close flag, quote kind capture
   always_comb begin
      quote_kind_in = quote_kind_ff;
      closed        = 1'b0;
      case (mode_ff)
         MODE_QUOTE: kind = KIND_MORE;
         MODE_TOKEN: begin
            kind   = head.sep ? KIND_END : KIND_MORE;
            closed = head.sep;
         end
         default: begin
            kind = head.sep ? KIND_SKIP : KIND_FIRST;
            if (!head.sep && (head.is_single || head.is_double)) begin
               quote_kind_in = head.is_double;
            end
         end
      endcase
      if (head.last && (kind == KIND_FIRST || kind == KIND_MORE)) begin
         closed = 1'b1;
      end
      rsp_in.char_out     = head.char_val;
      rsp_in.byte_kind    = kind;
      rsp_in.token_closed = closed;
      rsp_in.last_out     = head.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         quote_kind_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff       <= mode_in;
            quote_kind_ff <= quote_kind_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/quoted_token_splitter_core.sv
// Top level of the quoted token splitter: front, queue and back.
// Depends on qts_pkg, qts_front, qts_queue, qts_back and the defines header.
//
//   port group | direction | handshake           | payload
//   req_       | in        | req_valid/req_ready | req_type  (char_in, string_end)
//   rsp_       | out       | rsp_valid/rsp_ready | rsp_type  (one result per item)
//   csr_       | in        | csr_we              | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready stays high; an item's result passes the queue
// register, then the result register, before it is first offered on rsp_.
// The token state machine in the back end takes one item per cycle while the result stage is free or draining.
// Synchronous active-high reset clears state and queue and restores the
// tab/space separator map.
// A stalled rsp_ready fills the two-entry queue, then drops req_ready.
`include "quoted_token_splitter_core_defines.svh"
module quoted_token_splitter_core import qts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   class_type    cls;
   class_type    head;
   logic         head_valid;
   logic         pop;
   logic         push;
   logic         rsp_is_end;
   q_status_type q_status;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   qts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cls       (cls)
   );

   qts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (cls),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .status     (q_status)
   );

   qts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Checks
   assign rsp_is_end = rsp_valid && (rsp_data.byte_kind == KIND_END);

   `QTS_ASSERT_NOW(a_queue_status, clock, reset, 1'b1, !(q_status.full && q_status.empty))
   `QTS_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !q_status.empty)
   `QTS_ASSERT_NOW(a_end_closes, clock, reset, rsp_is_end, rsp_data.token_closed)
   `QTS_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !q_status.empty)

endmodule

>>> tb/quoted_token_splitter_core_tb.sv
// Self-checking testbench for quoted_token_splitter_core: directed rows, then random strings.
// Depends on qts_pkg and the quoted_token_splitter_core RTL; results are checked against typed rows or an
// in-bench byte classifier under random valid/ready idling.
`timescale 1ns / 100ps
module quoted_token_splitter_core_tb;
   import qts_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 200;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // One row of the directed table: a register write or an item with optional typed result
   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_sel;
      logic [63:0]          csr_val;
      logic [7:0]           ch;
      logic                 last;
      logic                 typed;
      kind_type             kind;
      logic                 closed;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Classifier state and separator map
   logic [63:0] sep_bits [SEP_WORDS];
   mode_type    tok_mode;
   logic        quote_dbl;

   rsp_type     classified_q [$];
   int unsigned error_count;
   int unsigned stall_cycles;
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   directed_row_type directed_rows [$] = '{
      // reset map: tab and space are separators
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE, 1'b0, 1'b1, KIND_SKIP,  1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h61,    1'b0, 1'b1, KIND_FIRST, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'hFF,    1'b0, 1'b1, KIND_MORE,  1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_TAB,   1'b0, 1'b1, KIND_END,   1'b1},
      // single-quoted token with a separator and the other quote inside
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_SINGLE, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE,     1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_DOUBLE, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_SINGLE, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h78,        1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE,     1'b0, 1'b0, KIND_SKIP, 1'b0},
      // unterminated double quote closed by end of string
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_DOUBLE, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h00,        1'b1, 1'b0, KIND_SKIP, 1'b0},
      // zero byte is ordinary under the reset map
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h00,    1'b0, 1'b1, KIND_FIRST, 1'b0},
      // end of string on an ending separator, a skipped one and a first byte
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE, 1'b1, 1'b1, KIND_END,   1'b1},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE, 1'b1, 1'b1, KIND_SKIP,  1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h62,    1'b1, 1'b1, KIND_FIRST, 1'b1},
      // quote in the middle of a token is ordinary
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'hFF,        1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_SINGLE, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, CH_SPACE,     1'b1, 1'b0, KIND_SKIP, 1'b0},
      // every value of the low word is a separator, quotes and zero included
      '{1'b1, CSR_SEP_MAP_0, ALL_ONES, 8'h00, 1'b0, 1'b0, KIND_SKIP, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_SINGLE, 1'b0, 1'b1, KIND_SKIP,  1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h41,        1'b0, 1'b1, KIND_FIRST, 1'b0},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, QUOTE_DOUBLE, 1'b0, 1'b1, KIND_END,   1'b1},
      '{1'b0, CSR_SEP_MAP_0, 64'd0, 8'h00,        1'b1, 1'b1, KIND_SKIP,  1'b0}
   };

   quoted_token_splitter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Classify one byte and advance the token state
   function automatic rsp_type classify_byte(req_type it);
      rsp_type  r;
      logic     sep;
      mode_type nxt;
      sep = sep_bits[it.char_in[7:6]][it.char_in[5:0]];
      nxt = tok_mode;
      r.char_out = it.char_in;
      r.token_closed = 1'b0;
      r.last_out = it.string_end;
      case (tok_mode)
         MODE_QUOTE: begin
            r.byte_kind = KIND_MORE;
            if (it.char_in == (quote_dbl ? QUOTE_DOUBLE : QUOTE_SINGLE))
               nxt = MODE_TOKEN;
         end
         MODE_TOKEN: begin
            if (sep) begin
               r.byte_kind = KIND_END;
               r.token_closed = 1'b1;
               nxt = MODE_IDLE;
            end else begin
               r.byte_kind = KIND_MORE;
            end
         end
         default: begin
            if (sep) begin
               r.byte_kind = KIND_SKIP;
               nxt = MODE_IDLE;
            end else begin
               r.byte_kind = KIND_FIRST;
               if (it.char_in == QUOTE_SINGLE || it.char_in == QUOTE_DOUBLE) begin
                  quote_dbl = (it.char_in == QUOTE_DOUBLE);
                  nxt = MODE_QUOTE;
               end else begin
                  nxt = MODE_TOKEN;
               end
            end
         end
      endcase
      // end of string closes any open token
      if (it.string_end) begin
         if (r.byte_kind == KIND_FIRST || r.byte_kind == KIND_MORE)
            r.token_closed = 1'b1;
         nxt = MODE_IDLE;
      end
      tok_mode = nxt;
      return r;
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return sep_bits[c[7:6]][c[5:0]];
   endfunction

   // Random byte of the wanted separator class; falls back to any byte
   function automatic logic [7:0] pick_byte(logic want_sep);
      logic [7:0] c;
      c = 8'($urandom);
      for (int i = 0; i < 16; i++) begin
         if (is_sep(c) == want_sep)
            return c;
         c = 8'($urandom);
      end
      return c;
   endfunction

   // Send one item; queue either the typed or the classified result
   task automatic send_item(input req_type it, input logic typed, input rsp_type typed_rsp);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      pred = classify_byte(it);
      classified_q.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (classified_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sep_bits[idx] = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Build one string: mostly well-formed tokens, some noise; returns its length
   task automatic send_string(output int unsigned sent);
      logic [7:0] bytes_q [$];
      logic [7:0] q;
      logic [7:0] c;
      req_type    it;
      int unsigned n;
      if ($urandom_range(99) < 20) begin
         n = $urandom_range(10, 1);
         repeat (n) bytes_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(4)) begin
            repeat ($urandom_range(2)) bytes_q.push_back(pick_byte(1'b1));
            if ($urandom_range(1)) begin
               q = $urandom_range(1) ? QUOTE_DOUBLE : QUOTE_SINGLE;
               bytes_q.push_back(q);
               repeat ($urandom_range(5)) begin
                  case ($urandom_range(3))
                     0: c = pick_byte(1'b1);
                     1: c = (q == QUOTE_DOUBLE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                     default: c = 8'($urandom);
                  endcase
                  if (c == q)
                     c = 8'h2E;
                  bytes_q.push_back(c);
               end
               if ($urandom_range(9) != 0)
                  bytes_q.push_back(q);
               repeat ($urandom_range(2)) bytes_q.push_back(pick_byte(1'b0));
            end else begin
               repeat ($urandom_range(5, 1)) bytes_q.push_back(pick_byte(1'b0));
            end
            if ($urandom_range(1))
               bytes_q.push_back(pick_byte(1'b1));
         end
         if (bytes_q.size() == 0)
            bytes_q.push_back(8'($urandom));
      end
      sent = bytes_q.size();
      for (int i = 0; i < bytes_q.size(); i++) begin
         it.char_in = bytes_q[i];
         it.string_end = (i == bytes_q.size() - 1);
         send_item(it, 1'b0, '0);
      end
   endtask

   // Result checker and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (classified_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: char %h kind %0d closed %b last %b",
                        rsp_data.char_out, rsp_data.byte_kind, rsp_data.token_closed,
                        rsp_data.last_out);
         end else begin
            want = classified_q.pop_front();
            if (rsp_data.char_out !== want.char_out || rsp_data.byte_kind !== want.byte_kind ||
                rsp_data.token_closed !== want.token_closed ||
                rsp_data.last_out !== want.last_out) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected char %h kind %0d closed %b last %b,",
                           want.char_out, want.byte_kind, want.token_closed, want.last_out,
                           " got char %h kind %0d closed %b last %b",
                           rsp_data.char_out, rsp_data.byte_kind, rsp_data.token_closed,
                           rsp_data.last_out);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: cycles without any handshake or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [63:0] cfg [SEP_WORDS];
      req_type     it;
      rsp_type     exp;
      int unsigned phase_items;
      int unsigned n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_SEP_MAP_0;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      sep_bits[CSR_SEP_MAP_0] = SEP_MAP_0_RESET;
      sep_bits[CSR_SEP_MAP_1] = '0;
      sep_bits[CSR_SEP_MAP_2] = '0;
      sep_bits[CSR_SEP_MAP_3] = '0;
      tok_mode = MODE_IDLE;
      quote_dbl = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_idle();
            write_csr(directed_rows[i].csr_sel, directed_rows[i].csr_val);
         end else begin
            it.char_in = directed_rows[i].ch;
            it.string_end = directed_rows[i].last;
            exp.char_out = directed_rows[i].ch;
            exp.byte_kind = directed_rows[i].kind;
            exp.token_closed = directed_rows[i].closed;
            exp.last_out = directed_rows[i].last;
            send_item(it, directed_rows[i].typed, exp);
         end
      end

      // Random phases: new separator map and idling mix per phase
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cfg = '{SEP_MAP_0_RESET, 64'd0, 64'd0, 64'd0};
            2: cfg = '{64'd0, 64'd0, 64'd0, 64'd0};
            3: cfg = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};
            4: cfg = '{64'h0800_1001_0000_2600, 64'h1000_0000_0000_0000, 64'd0, 64'd0};
            5: for (int w = 0; w < SEP_WORDS; w++)
                  cfg[w] = {$urandom, $urandom} | {$urandom, $urandom};
            default: for (int w = 0; w < SEP_WORDS; w++)
                  cfg[w] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         endcase
         // quotes as separators in one phase
         if (p == 6)
            cfg[CSR_SEP_MAP_0] = cfg[CSR_SEP_MAP_0] | (64'd1 << QUOTE_SINGLE) |
                                 (64'd1 << QUOTE_DOUBLE);
         wait_idle();
         write_csr(CSR_SEP_MAP_0, cfg[0]);
         write_csr(CSR_SEP_MAP_1, cfg[1]);
         write_csr(CSR_SEP_MAP_2, cfg[2]);
         write_csr(CSR_SEP_MAP_3, cfg[3]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 51; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_string(n);
            phase_items += n;
         end
      end

      // Drain, let the pipeline settle, then report
      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && classified_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
